>>> rtl/core/hash_dictionary_synonym_chain_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hash dictionary block
// Same-cycle and next-cycle implication checks with reset disable.
// ----------------------------------------------------------------------------
`ifndef HASH_DICTIONARY_SYNONYM_CHAIN_ASSERT_SVH
`define HASH_DICTIONARY_SYNONYM_CHAIN_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HDSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hdsc same-cycle check failed");

// antecedent implies consequent in the next cycle
`define HDSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hdsc next-cycle check failed");

`endif

>>> rtl/core/hdsc_pkg.sv
// ----------------------------------------------------------------------------
// hdsc_pkg
// Types, codes and defaults shared by the hash dictionary modules.
// ----------------------------------------------------------------------------
package hdsc_pkg;

    // default geometry
    localparam int PRIME_SLOTS_DEF = 16;
    localparam int TOTAL_SLOTS_DEF = 32;

    // keys are hashed relative to lower-case 'a'
    localparam int KEY_BASE = 97;

    // request codes (code 3 behaves as a query)
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_QUERY  = 2'd2
    } action_t;

    // result codes
    typedef enum logic [2:0] {
        RES_INSERTED    = 3'd0,
        RES_PRESENT     = 3'd1,
        RES_OVERFLOW    = 3'd2,
        RES_DELETED     = 3'd3,
        RES_NOT_PRESENT = 3'd4,
        RES_FOUND       = 3'd5,
        RES_NOT_FOUND   = 3'd6
    } result_t;

    // prime slot status, empty must encode as zero
    typedef enum logic [1:0] {
        SLOT_EMPTY   = 2'd0,
        SLOT_USED    = 2'd1,
        SLOT_DELETED = 2'd2
    } slot_state_t;

    // sequencer states
    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_HOME,
        FSM_WALK,
        FSM_RESP
    } fsm_state_t;

endpackage

>>> rtl/core/hdsc_prime_ram.sv
// ----------------------------------------------------------------------------
// hdsc_prime_ram
// Prime area storage: synchronous RAM with per-entry valid bits so that an
// entry never written since reset reads as all zeros (empty, null link).
// ----------------------------------------------------------------------------
module hdsc_prime_ram #(
    parameter int DEPTH = hdsc_pkg::PRIME_SLOTS_DEF,
    parameter int AW    = 4,
    parameter int WIDTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_q_reg;
    logic             rd_valid_reg;

    // array write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // valid bits and the valid flag of the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // unwritten entry reads as the reset value
    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

>>> rtl/core/hdsc_syn_ram.sv
// ----------------------------------------------------------------------------
// hdsc_syn_ram
// Synonym area storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hdsc_syn_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int WIDTH = 14
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_q_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_q_reg;

endmodule

>>> rtl/core/hash_dictionary_synonym_chain.sv
// ----------------------------------------------------------------------------
// hash_dictionary_synonym_chain
// Byte-key set with a prime area and a linked synonym overflow area.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                            | Direction
//  --------+------------------------------------+----------
//  request | in_valid, in_stall, action, key    | in
//  result  | out_valid, out_stall, status, found| out
//
// One transaction at a time: accept in idle, home slot decision, then one
// walk state per synonym link followed (n, 0 .. TOTAL_SLOTS-PRIME_SLOTS),
// one synonym RAM read per link, then the response state loads the result
// register. Reset is asynchronous, active low; the prime area reads empty at
// once through its valid bits, no clearing pass. A result still stalled in
// the output register holds the next transaction in its response state;
// in_stall is high until it is taken.
// ----------------------------------------------------------------------------
`include "hash_dictionary_synonym_chain_assert.svh"

module hash_dictionary_synonym_chain #(
    parameter int PRIME_SLOTS = hdsc_pkg::PRIME_SLOTS_DEF,
    parameter int TOTAL_SLOTS = hdsc_pkg::TOTAL_SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  logic [7:0] key,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic       found
);

    // geometry
    localparam int MaxSlots  = (TOTAL_SLOTS > PRIME_SLOTS) ? TOTAL_SLOTS : PRIME_SLOTS;
    localparam int SynDepth  = (TOTAL_SLOTS > PRIME_SLOTS) ? TOTAL_SLOTS - PRIME_SLOTS : 1;
    localparam int PAW       = $clog2(PRIME_SLOTS);
    localparam int IW        = $clog2(MaxSlots);
    localparam int SAW       = (SynDepth > 1) ? $clog2(SynDepth) : 1;
    localparam int NFW       = $clog2(MaxSlots + 1);
    localparam int KeyOffset =
        (PRIME_SLOTS - (hdsc_pkg::KEY_BASE % PRIME_SLOTS)) % PRIME_SLOTS;

    typedef struct packed {
        hdsc_pkg::slot_state_t st;
        logic [7:0]            key;
        logic                  lv;
        logic [IW-1:0]         link;
    } prime_ent_t;

    typedef struct packed {
        logic [7:0]    key;
        logic          lv;
        logic [IW-1:0] link;
    } syn_ent_t;

    localparam int PW = $bits(prime_ent_t);
    localparam int SW = $bits(syn_ent_t);

    // home slot of every byte key, (key - 'a') mod PRIME_SLOTS
    function automatic logic [256*PAW-1:0] build_home_lut();
        logic [256*PAW-1:0] lut;
        int                 v;
        lut = '0;
        for (int k = 0; k < 256; k++)
        begin
            v = k + KeyOffset;
            while (v >= PRIME_SLOTS)
            begin
                v = v - PRIME_SLOTS;
            end
            lut[k*PAW +: PAW] = PAW'(v);
        end
        return lut;
    endfunction

    localparam logic [256*PAW-1:0] HomeLut = build_home_lut();

    // slot index to synonym RAM address
    function automatic logic [SAW-1:0] syn_addr(input logic [IW-1:0] idx);
        logic [IW-1:0] diff;
        diff = idx - IW'(PRIME_SLOTS);
        return diff[SAW-1:0];
    endfunction

    // state and payload registers
    hdsc_pkg::fsm_state_t state_reg, state_next;
    logic [NFW-1:0]       nf_reg, nf_next;
    logic                 out_valid_reg, out_valid_next;
    hdsc_pkg::result_t    out_status_reg, out_status_next;
    logic                 out_found_reg, out_found_next;
    logic [1:0]           act_reg, act_next;
    logic [7:0]           key_reg, key_next;
    logic [PAW-1:0]       home_reg, home_next;
    prime_ent_t           home_ent_reg, home_ent_next;
    logic [IW-1:0]        cur_reg, cur_next;
    logic [IW-1:0]        prev_reg, prev_next;
    syn_ent_t             prev_ent_reg, prev_ent_next;
    logic                 prev_prime_reg, prev_prime_next;
    hdsc_pkg::result_t    res_status_reg, res_status_next;
    logic                 res_found_reg, res_found_next;

    // memory ports
    logic           prime_rd_en, prime_wr_en;
    logic [PAW-1:0] prime_rd_addr;
    logic [PW-1:0]  prime_rd_data;
    prime_ent_t     prime_wr_data;
    logic           syn_rd_en, syn_wr_en;
    logic [SAW-1:0] syn_rd_addr, syn_wr_addr;
    logic [SW-1:0]  syn_rd_data;
    syn_ent_t       syn_wr_data;

    // decoded read data
    prime_ent_t     pe;
    syn_ent_t       se;
    prime_ent_t     hent;
    logic [PAW-1:0] home_in;
    logic           is_insert, is_delete;
    logic           home_empty, home_match, home_walk;
    logic           syn_match, walk_more;
    logic           out_free;
    logic           miss_end;

    assign home_in    = HomeLut[key*PAW +: PAW];
    assign pe         = prime_ent_t'(prime_rd_data);
    assign se         = syn_ent_t'(syn_rd_data);
    assign hent       = (state_reg == hdsc_pkg::FSM_HOME) ? pe : home_ent_reg;
    assign is_insert  = act_reg == hdsc_pkg::ACT_INSERT;
    assign is_delete  = act_reg == hdsc_pkg::ACT_DELETE;
    assign home_empty = pe.st == hdsc_pkg::SLOT_EMPTY;
    assign home_match = (pe.st == hdsc_pkg::SLOT_USED) && (pe.key == key_reg);
    assign home_walk  = !home_empty && !home_match && pe.lv;
    assign syn_match  = se.key == key_reg;
    assign walk_more  = !syn_match && se.lv;
    assign out_free   = !out_valid_reg || !out_stall;

    // memories
    hdsc_prime_ram #(
        .DEPTH (PRIME_SLOTS),
        .AW    (PAW),
        .WIDTH (PW)
    ) u_prime_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (prime_rd_en),
        .rd_addr (prime_rd_addr),
        .rd_data (prime_rd_data),
        .wr_en   (prime_wr_en),
        .wr_addr (home_reg),
        .wr_data (prime_wr_data)
    );

    hdsc_syn_ram #(
        .DEPTH (SynDepth),
        .AW    (SAW),
        .WIDTH (SW)
    ) u_syn_ram (
        .clk     (clk),
        .rd_en   (syn_rd_en),
        .rd_addr (syn_rd_addr),
        .rd_data (syn_rd_data),
        .wr_en   (syn_wr_en),
        .wr_addr (syn_wr_addr),
        .wr_data (syn_wr_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hdsc_pkg::FSM_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = hdsc_pkg::FSM_HOME;
                end
            end
            hdsc_pkg::FSM_HOME:
            begin
                state_next = home_walk ? hdsc_pkg::FSM_WALK : hdsc_pkg::FSM_RESP;
            end
            hdsc_pkg::FSM_WALK:
            begin
                state_next = walk_more ? hdsc_pkg::FSM_WALK : hdsc_pkg::FSM_RESP;
            end
            hdsc_pkg::FSM_RESP:
            begin
                if (out_free)
                begin
                    state_next = hdsc_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = hdsc_pkg::FSM_IDLE;
            end
        endcase
    end

    // datapath, memory accesses and result
    always_comb
    begin
        act_next        = act_reg;
        key_next        = key_reg;
        home_next       = home_reg;
        home_ent_next   = home_ent_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        prev_ent_next   = prev_ent_reg;
        prev_prime_next = prev_prime_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        nf_next         = nf_reg;
        prime_rd_en     = 1'b0;
        prime_rd_addr   = home_in;
        prime_wr_en     = 1'b0;
        prime_wr_data   = '0;
        syn_rd_en       = 1'b0;
        syn_rd_addr     = '0;
        syn_wr_en       = 1'b0;
        syn_wr_addr     = '0;
        syn_wr_data     = '0;
        miss_end        = 1'b0;

        case (state_reg)
            // capture the transaction and read its home slot
            hdsc_pkg::FSM_IDLE:
            begin
                if (in_valid)
                begin
                    act_next    = action;
                    key_next    = key;
                    home_next   = home_in;
                    prime_rd_en = 1'b1;
                end
            end

            // decide on the home slot
            hdsc_pkg::FSM_HOME:
            begin
                home_ent_next = pe;
                if (home_empty)
                begin
                    if (is_insert)
                    begin
                        prime_wr_en     = 1'b1;
                        prime_wr_data   = '{hdsc_pkg::SLOT_USED, key_reg, pe.lv, pe.link};
                        res_status_next = hdsc_pkg::RES_INSERTED;
                    end
                    else if (is_delete)
                    begin
                        res_status_next = hdsc_pkg::RES_NOT_PRESENT;
                    end
                    else
                    begin
                        res_status_next = hdsc_pkg::RES_NOT_FOUND;
                    end
                    res_found_next = 1'b0;
                end
                else if (home_match)
                begin
                    if (is_insert)
                    begin
                        res_status_next = hdsc_pkg::RES_PRESENT;
                    end
                    else if (is_delete)
                    begin
                        prime_wr_en     = 1'b1;
                        prime_wr_data   = '{hdsc_pkg::SLOT_DELETED, pe.key, pe.lv, pe.link};
                        res_status_next = hdsc_pkg::RES_DELETED;
                    end
                    else
                    begin
                        res_status_next = hdsc_pkg::RES_FOUND;
                    end
                    res_found_next = 1'b1;
                end
                else if (pe.lv)
                begin
                    cur_next        = pe.link;
                    prev_prime_next = 1'b1;
                    syn_rd_en       = 1'b1;
                    syn_rd_addr     = syn_addr(pe.link);
                end
                else
                begin
                    miss_end = 1'b1;
                end
            end

            // follow one synonym link
            hdsc_pkg::FSM_WALK:
            begin
                if (syn_match)
                begin
                    if (is_insert)
                    begin
                        res_status_next = hdsc_pkg::RES_PRESENT;
                    end
                    else if (is_delete)
                    begin
                        // unlink: predecessor takes over the hit's link
                        if (prev_prime_reg)
                        begin
                            prime_wr_en   = 1'b1;
                            prime_wr_data = '{home_ent_reg.st, home_ent_reg.key,
                                              se.lv, se.link};
                        end
                        else
                        begin
                            syn_wr_en   = 1'b1;
                            syn_wr_addr = syn_addr(prev_reg);
                            syn_wr_data = '{prev_ent_reg.key, se.lv, se.link};
                        end
                        res_status_next = hdsc_pkg::RES_DELETED;
                    end
                    else
                    begin
                        res_status_next = hdsc_pkg::RES_FOUND;
                    end
                    res_found_next = 1'b1;
                end
                else if (se.lv)
                begin
                    prev_next       = cur_reg;
                    prev_ent_next   = se;
                    prev_prime_next = 1'b0;
                    cur_next        = se.link;
                    syn_rd_en       = 1'b1;
                    syn_rd_addr     = syn_addr(se.link);
                end
                else
                begin
                    miss_end = 1'b1;
                end
            end

            hdsc_pkg::FSM_RESP:
            begin
            end

            default:
            begin
            end
        endcase

        // key absent from the home slot and its whole chain
        if (miss_end)
        begin
            res_found_next = 1'b0;
            if (is_insert)
            begin
                if (hent.st == hdsc_pkg::SLOT_DELETED)
                begin
                    prime_wr_en     = 1'b1;
                    prime_wr_data   = '{hdsc_pkg::SLOT_USED, key_reg, hent.lv, hent.link};
                    res_status_next = hdsc_pkg::RES_INSERTED;
                end
                else if (nf_reg < NFW'(TOTAL_SLOTS))
                begin
                    // new synonym entry at the head of the chain
                    syn_wr_en       = 1'b1;
                    syn_wr_addr     = syn_addr(IW'(nf_reg));
                    syn_wr_data     = '{key_reg, hent.lv, hent.link};
                    prime_wr_en     = 1'b1;
                    prime_wr_data   = '{hent.st, hent.key, 1'b1, IW'(nf_reg)};
                    nf_next         = nf_reg + 1'b1;
                    res_status_next = hdsc_pkg::RES_INSERTED;
                end
                else
                begin
                    res_status_next = hdsc_pkg::RES_OVERFLOW;
                end
            end
            else if (is_delete)
            begin
                res_status_next = hdsc_pkg::RES_NOT_PRESENT;
            end
            else
            begin
                res_status_next = hdsc_pkg::RES_NOT_FOUND;
            end
        end
    end

    // output register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == hdsc_pkg::FSM_RESP) && out_free)
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_found_next  = res_found_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hdsc_pkg::FSM_IDLE;
            nf_reg        <= NFW'(PRIME_SLOTS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nf_reg        <= nf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        key_reg        <= key_next;
        home_reg       <= home_next;
        home_ent_reg   <= home_ent_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        prev_ent_reg   <= prev_ent_next;
        prev_prime_reg <= prev_prime_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
    end

    assign in_stall  = state_reg != hdsc_pkg::FSM_IDLE;
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign found     = out_found_reg;

    // checks
    `HDSC_ASSERT_NEXT(a_accept_reads_home, clk, rst_n, in_valid && !in_stall, state_reg == hdsc_pkg::FSM_HOME)
    `HDSC_ASSERT_NOW(a_syn_write_has_room, clk, rst_n, syn_wr_en && is_insert, nf_reg < NFW'(TOTAL_SLOTS))
    `HDSC_ASSERT_NEXT(a_next_free_monotonic, clk, rst_n, 1'b1, nf_reg >= $past(nf_reg))
    `HDSC_ASSERT_NOW(a_write_only_at_end, clk, rst_n, prime_wr_en || syn_wr_en, state_next == hdsc_pkg::FSM_RESP)

endmodule
